/* src/q2e_pkg.sv */
// Shared types, constants and arithmetic helpers for the quaternion to Euler block.
// Used by q2e_front, q2e_queue, q2e_back and quaternion_to_euler; no dependencies.
`default_nettype none
package q2e_pkg;

  typedef logic signed [63:0] wide_t;

  localparam wide_t ANG_PI      = 64'sd3373259426;
  localparam wide_t ANG_HALF_PI = 64'sd1686629713;
  localparam wide_t OUT_PI      = 64'sd25736;
  localparam wide_t OUT_HALF_PI = 64'sd12868;
  localparam wide_t ONE_Q58     = 64'sh0400_0000_0000_0000;
  localparam wide_t HALF_Q58    = 64'sh0200_0000_0000_0000;
  localparam wide_t RND_HALF    = 64'sd65536;

  localparam int MAX_STEPS  = 24;
  localparam int SQRT_STEPS = 32;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  typedef wide_t atan_tab_t [MAX_STEPS];
  localparam atan_tab_t ATAN_TAB = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
    64'sd4194283,   64'sd2097137,   64'sd1048574,   64'sd524288,
    64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
    64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
    64'sd1024,      64'sd512,       64'sd256,       64'sd128
  };

  // Work item handed from the front to the back.
  typedef struct packed {
    wide_t       rs;
    wide_t       rc;
    wide_t       hs;
    wide_t       hc;
    logic [63:0] sa_arg;
    logic [63:0] sb_arg;
  } qitem_t;

  // Square-root pipeline stage payload.
  typedef struct packed {
    logic [63:0] va;
    logic [63:0] ra;
    logic [63:0] vb;
    logic [63:0] rb;
    wide_t       rs;
    wide_t       rc;
    wide_t       hs;
    wide_t       hc;
  } sqst_t;

  // One CORDIC vectoring lane.
  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
    logic  zero;
  } cvec_t;

  function automatic void sqrt_iter(input logic [63:0] v, input logic [63:0] r,
                                    input logic [63:0] b, output logic [63:0] v_o,
                                    output logic [63:0] r_o);
    logic [63:0] sum;
    sum = r + b;
    if (v >= sum) begin
      v_o = v - sum;
      r_o = (r >> 1) + b;
    end else begin
      v_o = v;
      r_o = r >> 1;
    end
  endfunction

  function automatic cvec_t cordic_pre(input wide_t y, input wide_t x);
    cvec_t c;
    c.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      c.z = (y >= 0) ? ANG_PI : -ANG_PI;
      c.x = -x;
      c.y = -y;
    end else begin
      c.z = '0;
      c.x = x;
      c.y = y;
    end
    return c;
  endfunction

  function automatic cvec_t cordic_iter(input cvec_t c, input int i);
    cvec_t o;
    wide_t dx;
    wide_t dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    o.zero = c.zero;
    if (c.y > 0) begin
      o.x = c.x + dx;
      o.y = c.y - dy;
      o.z = c.z + ATAN_TAB[i];
    end else begin
      o.x = c.x - dx;
      o.y = c.y + dy;
      o.z = c.z - ATAN_TAB[i];
    end
    return o;
  endfunction

  // Round to Q3.13 (nearest, ties away from zero), then saturate to +-lim.
  function automatic logic [15:0] angle_out(input wide_t z, input wide_t lim);
    wide_t r;
    if (z >= 0) begin
      r = (z + RND_HALF) >>> 17;
    end else begin
      r = -((-z + RND_HALF) >>> 17);
    end
    if (r > lim) begin
      r = lim;
    end
    if (r < -lim) begin
      r = -lim;
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

/* src/q2e_front.sv */
// Front end: accepts a quaternion, forms the nine products and the atan2/sqrt arguments.
// Depends on q2e_pkg.
`default_nettype none
module q2e_front import q2e_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [SAMPLE_WIDTH-1:0] w_i,
  input  wire logic [SAMPLE_WIDTH-1:0] x_i,
  input  wire logic [SAMPLE_WIDTH-1:0] y_i,
  input  wire logic [SAMPLE_WIDTH-1:0] z_i,
  input  wire logic                    q_full,
  output logic                         push,
  output qitem_t                       item
);

  logic signed [29:0] cw, cx, cy, cz;
  logic signed [59:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, xz_r;
  logic               p1_v_r;
  logic               f2_v_r;
  qitem_t             f2_r;
  qitem_t             f2_nxt;
  logic               fen;
  wide_t              t_raw, t_cl;

  // Align each sample to Q1.29.
  if (SAMPLE_WIDTH <= 30) begin : g_up
    always_comb begin
      cw = 30'(signed'(w_i)) <<< (30 - SAMPLE_WIDTH);
      cx = 30'(signed'(x_i)) <<< (30 - SAMPLE_WIDTH);
      cy = 30'(signed'(y_i)) <<< (30 - SAMPLE_WIDTH);
      cz = 30'(signed'(z_i)) <<< (30 - SAMPLE_WIDTH);
    end
  end else begin : g_down
    always_comb begin
      cw = 30'(signed'(w_i) >>> (SAMPLE_WIDTH - 30));
      cx = 30'(signed'(x_i) >>> (SAMPLE_WIDTH - 30));
      cy = 30'(signed'(y_i) >>> (SAMPLE_WIDTH - 30));
      cz = 30'(signed'(z_i) >>> (SAMPLE_WIDTH - 30));
    end
  end

  assign fen      = !(f2_v_r && q_full);
  assign in_ready = fen;
  assign push     = f2_v_r && !q_full;
  assign item     = f2_r;

  always_comb begin
    f2_nxt.rs = (64'(wx_r) + 64'(yz_r)) <<< 1;
    f2_nxt.rc = ONE_Q58 - ((64'(xx_r) + 64'(yy_r)) <<< 1);
    f2_nxt.hs = (64'(wz_r) + 64'(xy_r)) <<< 1;
    f2_nxt.hc = ONE_Q58 - ((64'(yy_r) + 64'(zz_r)) <<< 1);
    t_raw = 64'(wy_r) - 64'(xz_r);
    if (t_raw > HALF_Q58) begin
      t_cl = HALF_Q58;
    end else if (t_raw < -HALF_Q58) begin
      t_cl = -HALF_Q58;
    end else begin
      t_cl = t_raw;
    end
    f2_nxt.sa_arg = ONE_Q58 + (t_cl <<< 1);
    f2_nxt.sb_arg = ONE_Q58 - (t_cl <<< 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (fen) begin
      p1_v_r <= in_valid;
      f2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      wx_r <= cw * cx;
      yz_r <= cy * cz;
      xx_r <= cx * cx;
      yy_r <= cy * cy;
      wz_r <= cw * cz;
      xy_r <= cx * cy;
      zz_r <= cz * cz;
      wy_r <= cw * cy;
      xz_r <= cx * cz;
      f2_r <= f2_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/q2e_queue.sv */
// Short register FIFO between front and back.
// Depends on q2e_pkg.
`default_nettype none
module q2e_queue import q2e_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire qitem_t din,
  input  wire logic   pop,
  output logic        full,
  output logic        empty,
  output qitem_t      dout
);

  qitem_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_r, rd_r;
  logic [QPTR_W:0]    cnt_r;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule
`default_nettype wire

/* src/q2e_back.sv */
// Back end: square-root pipeline, three CORDIC vectoring pipelines and the output register.
// Depends on q2e_pkg.
`default_nettype none
module q2e_back import q2e_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_empty,
  input  wire qitem_t q_item,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [15:0] roll_o,
  output logic [14:0] pitch_o,
  output logic [15:0] head_o
);

  localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  logic  en;
  sqst_t sq_r [SQRT_STEPS+1];
  logic  sv_r [SQRT_STEPS+1];
  cvec_t cv_r [NSTEP+1][3];
  logic  cvv_r [NSTEP+1];
  logic  ov_r;
  logic [15:0] roll_r, head_r;
  logic [14:0] pitch_r;
  logic [15:0] pitch_w;
  wide_t zr, zp, zh;

  assign en        = !ov_r || out_ready;
  assign pop       = en && !q_empty;
  assign out_valid = ov_r;
  assign roll_o    = roll_r;
  assign pitch_o   = pitch_r;
  assign head_o    = head_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0].va <= q_item.sa_arg;
      sq_r[0].ra <= '0;
      sq_r[0].vb <= q_item.sb_arg;
      sq_r[0].rb <= '0;
      sq_r[0].rs <= q_item.rs;
      sq_r[0].rc <= q_item.rc;
      sq_r[0].hs <= q_item.hs;
      sq_r[0].hc <= q_item.hc;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    sqst_t s_nxt;
    always_comb begin
      s_nxt = sq_r[k];
      sqrt_iter(sq_r[k].va, sq_r[k].ra, BIT, s_nxt.va, s_nxt.ra);
      sqrt_iter(sq_r[k].vb, sq_r[k].rb, BIT, s_nxt.vb, s_nxt.rb);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k+1] <= s_nxt;
      end
    end
  end

  // Lanes: roll, pitch, heading.
  always_ff @(posedge clk) begin
    if (en) begin
      cv_r[0][0] <= cordic_pre(sq_r[SQRT_STEPS].rs, sq_r[SQRT_STEPS].rc);
      cv_r[0][1] <= cordic_pre(wide_t'(sq_r[SQRT_STEPS].ra), wide_t'(sq_r[SQRT_STEPS].rb));
      cv_r[0][2] <= cordic_pre(sq_r[SQRT_STEPS].hs, sq_r[SQRT_STEPS].hc);
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    for (genvar l = 0; l < 3; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (en) begin
          cv_r[i+1][l] <= cordic_iter(cv_r[i][l], i);
        end
      end
    end
  end

  always_comb begin
    zr = cv_r[NSTEP][0].zero ? '0 : cv_r[NSTEP][0].z;
    zp = cv_r[NSTEP][1].zero ? '0 : cv_r[NSTEP][1].z;
    zh = cv_r[NSTEP][2].zero ? '0 : cv_r[NSTEP][2].z;
    pitch_w = angle_out((zp <<< 1) - ANG_HALF_PI, OUT_HALF_PI);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= angle_out(zr, OUT_PI);
      pitch_r <= pitch_w[14:0];
      head_r  <= angle_out(zh, OUT_PI);
    end
  end

  // Valid tags advance in lockstep with the payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SQRT_STEPS; k++) begin
        sv_r[k] <= 1'b0;
      end
      for (int i = 0; i <= NSTEP; i++) begin
        cvv_r[i] <= 1'b0;
      end
      ov_r <= 1'b0;
    end else if (en) begin
      sv_r[0] <= !q_empty;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sv_r[k+1] <= sv_r[k];
      end
      cvv_r[0] <= sv_r[SQRT_STEPS];
      for (int i = 0; i < NSTEP; i++) begin
        cvv_r[i+1] <= cvv_r[i];
      end
      ov_r <= cvv_r[NSTEP];
    end
  end

endmodule
`default_nettype wire

/* src/quaternion_to_euler.sv */
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on q2e_pkg, q2e_front, q2e_queue and q2e_back.
//
//  Channel | Ports                 | Carries
//  --------+-----------------------+-----------------------------------------------
//  in      | in_tvalid/tready/data | quat_w, quat_x, quat_y, quat_z (Q1.15)
//  out     | out_tvalid/tready/data| roll_angle, pitch_angle, heading_angle (Q3.13)
//
// One transaction enters per cycle and one leaves per cycle when both sides flow.
// Data passes the front product and item registers, the queue, the square-root input
// register, the 32-stage square-root pipeline, the CORDIC stages and the output register.
// Reset (rst_n low, synchronous) drops every transaction in flight.
// A stall at out holds the whole back pipeline; the front keeps accepting until the
// four-entry queue fills, then drops in_tready.
`default_nettype none
module quaternion_to_euler import q2e_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // quat_w, quat_x, quat_y, quat_z, each SAMPLE_WIDTH bits, lowest first; zero pad
  input  wire logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // roll_angle [15:0], pitch_angle [30:16], heading_angle [46:31], zero [47]
  output logic [47:0] out_tdata
);

  logic        q_full, q_empty, push, pop;
  qitem_t      f_item, q_item;
  logic [15:0] roll, head;
  logic [14:0] pitch;

  // Align the samples and form the products.
  q2e_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .w_i      (in_tdata[SAMPLE_WIDTH-1:0]),
    .x_i      (in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .y_i      (in_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]),
    .z_i      (in_tdata[4*SAMPLE_WIDTH-1:3*SAMPLE_WIDTH]),
    .q_full   (q_full),
    .push     (push),
    .item     (f_item)
  );

  // Decouple the two halves.
  q2e_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_item),
    .pop   (pop),
    .full  (q_full),
    .empty (q_empty),
    .dout  (q_item)
  );

  // Square roots, CORDIC and output register.
  q2e_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .roll_o    (roll),
    .pitch_o   (pitch),
    .head_o    (head)
  );

  assign out_tdata = {1'b0, head, pitch, roll};

endmodule
`default_nettype wire

/* bench/quaternion_to_euler_tb.sv */
// Self-checking bench for quaternion_to_euler: streams quaternions, predicts the
// roll/pitch/heading angles in Q3.13 and compares every output transaction.
// Depends on q2e_pkg and the quaternion_to_euler RTL.
module quaternion_to_euler_tb;
  import q2e_pkg::*;

  localparam int STEPS = 16;
  localparam int SW = 16;
  localparam int LIMIT = 1000000;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic [15:0] heading;
    logic [14:0] pitch;
    logic [15:0] roll;
  } euler_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;

  quat_t quat_pending[$];
  euler_t angles_due[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit stim_done = 1'b0;
  int mismatches = 0;
  int cycles = 0;
  int rounds = 0;
  int sent = 0;

  quaternion_to_euler #(.CORDIC_STEPS(STEPS), .SAMPLE_WIDTH(SW)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #2 clk = ~clk;

  // Pack w into the lowest bits, z into the highest.
  function automatic logic [63:0] quat_bits(quat_t q);
    return {q.z, q.y, q.x, q.w};
  endfunction

  function automatic quat_t quat_from_bits(logic [63:0] d);
    quat_t q;
    q.w = d[15:0];
    q.x = d[31:16];
    q.y = d[47:32];
    q.z = d[63:48];
    return q;
  endfunction

  // floor division by 2^s
  function automatic wide_t floor_shift(wide_t v, int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  function automatic wide_t vector_angle(wide_t ys, wide_t xs);
    wide_t xa, ya, za, dx, dy;
    xa = xs; ya = ys; za = 0;
    if (xa == 0 && ya == 0) return 0;
    if (xa < 0) begin
      za = (ya >= 0) ? ANG_PI : -ANG_PI;
      xa = -xa;
      ya = -ya;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_shift(ya, i);
      dy = floor_shift(xa, i);
      if (ya > 0) begin
        xa += dx; ya -= dy; za += ATAN_TAB[i];
      end else begin
        xa -= dx; ya += dy; za -= ATAN_TAB[i];
      end
    end
    return za;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic wide_t to_q13(wide_t za, wide_t lim);
    wide_t r;
    if (za >= 0) r = (za + 65536) >>> 17;
    else r = -((-za + 65536) >>> 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t euler_of(quat_t q);
    wide_t w, x, y, z, rs, rc, hs, hc, t, pa, r;
    logic [63:0] sa, sb;
    euler_t e;
    w = wide_t'(q.w) <<< 14;
    x = wide_t'(q.x) <<< 14;
    y = wide_t'(q.y) <<< 14;
    z = wide_t'(q.z) <<< 14;
    rs = 2 * (w * x + y * z);
    rc = ONE_Q58 - 2 * (x * x + y * y);
    hs = 2 * (w * z + x * y);
    hc = ONE_Q58 - 2 * (y * y + z * z);
    t = w * y - x * z;
    if (t > HALF_Q58) t = HALF_Q58;
    if (t < -HALF_Q58) t = -HALF_Q58;
    sa = root_floor(ONE_Q58 + 2 * t);
    sb = root_floor(ONE_Q58 - 2 * t);
    pa = 2 * vector_angle(wide_t'(sa), wide_t'(sb)) - ANG_HALF_PI;
    r = to_q13(vector_angle(rs, rc), OUT_PI);
    e.roll = r[15:0];
    r = to_q13(pa, OUT_HALF_PI);
    e.pitch = r[14:0];
    r = to_q13(vector_angle(hs, hc), OUT_PI);
    e.heading = r[15:0];
    return e;
  endfunction

  function automatic logic signed [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Driver: advance to a new transaction only after acceptance.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (quat_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tdata <= quat_bits(quat_pending.pop_front());
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: record accepted inputs, check accepted outputs in order.
  always @(posedge clk) begin
    euler_t got, want;
    cycles <= cycles + 1;
    if (rst_n && in_tvalid && in_tready) begin
      angles_due.push_back(euler_of(quat_from_bits(in_tdata)));
      sent <= sent + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = euler_t'(out_tdata[46:0]);
      if (angles_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected output %h", out_tdata);
      end else begin
        want = angles_due.pop_front();
        if (got !== want || out_tdata[47] !== 1'b0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("angle mismatch: roll %h/%h pitch %h/%h heading %h/%h (exp/act)",
                     want.roll, got.roll, want.pitch, got.pitch,
                     want.heading, got.heading);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    quat_t q;
    // directed: identity, extremes, gimbal lock, zero vector, all-negative
    quat_pending.push_back('{16'sh7fff, 0, 0, 0});
    quat_pending.push_back('{0, 0, 0, 0});
    quat_pending.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    quat_pending.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    quat_pending.push_back('{16'sh5a82, 0, 16'sh5a82, 0});
    quat_pending.push_back('{16'sh5a82, 0, -16'sh5a82, 0});
    quat_pending.push_back('{16'sh7fff, 0, 16'sh7fff, 0});
    quat_pending.push_back('{16'sh7fff, 16'sh7fff, 0, 16'sh8000});
    quat_pending.push_back('{0, 16'sh7fff, 0, 0});
    quat_pending.push_back('{0, 0, 0, 16'sh7fff});
    quat_pending.push_back('{0, 0, 16'sh7fff, 0});
    quat_pending.push_back('{16'sh8000, 16'sh0001, 0, 16'shffff});
    quat_pending.push_back('{0, 16'sh5a82, 0, 16'sh5a82});
    quat_pending.push_back('{16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000});
    quat_pending.push_back('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 48 : 27) : 0;
      recv_stall_pct = (ph == 2) ? 48 : (ph == 3 ? 27 : 0);
      for (int n = 0; n < 450; n++) begin
        if ($urandom_range(0, 2) == 0) begin
          q = quat_t'({$urandom, $urandom});
        end else begin
          q.w = pick16(); q.x = pick16(); q.y = pick16(); q.z = pick16();
          if ($urandom_range(0, 3) == 0) q.z = q.x;
        end
        quat_pending.push_back(q);
      end
      wait (quat_pending.size() == 0 && !in_tvalid);
    end
    wait (angles_due.size() == 0);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && angles_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* sim.f */
src/q2e_pkg.sv
src/q2e_front.sv
src/q2e_queue.sv
src/q2e_back.sv
src/quaternion_to_euler.sv
bench/quaternion_to_euler_tb.sv
